>>> hdl/fbr_pkg.sv
package fbr_pkg;

    localparam int STORE_DEPTH  = 1024;
    localparam int INIT_PAYLOAD = 61;
    localparam int CONT_PAYLOAD = 63;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int LEN_W   = $clog2(STORE_DEPTH + 1);
    localparam int BIF_W   = 10;
    localparam int FPOS_W  = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [BIF_W-1:0] POS_MAX = {BIF_W{1'b1}};
    localparam logic [7:0] INIT_MARK  = 8'h80;
    localparam logic [7:0] CODE_CANCEL = 8'h05;
    localparam logic [7:0] CODE_OTHER  = 8'h01;

    localparam logic [CFG_IDX_W-1:0] CFG_LINK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CANCEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR  = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_REQ,
        MODE_PING,
        MODE_ERR
    } mode_t;

    typedef struct packed {
        logic             chan;
        logic [7:0]       data;
        logic             use_mem;
        logic             valid;
        logic             eof;
        logic             eom;
        logic [LEN_W-1:0] len;
    } res_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [15:0] v);
        if (v > 16'(STORE_DEPTH))
            return LEN_W'(STORE_DEPTH);
        else
            return v[LEN_W-1:0];
    endfunction

endpackage

>>> hdl/fido_ble_fragment_reassembler.sv
// Reassembles BLE control-point writes (one byte per beat) into a message held in a
// 1024-byte RAM and answers it on pull beats: request bytes on channel 0, ping echo or
// error notifications on channel 1. One input beat is taken every cycle unless the output
// stage is full; each beat writes or reads at most one RAM entry, and a result from a pull
// beat passes through a two-entry output stage (RAM read stage plus output register), so a
// stalled output only holds up input once both entries are full.
module fido_ble_fragment_reassembler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic [7:0]                     rx_byte,
    input  logic                           first_of_fragment,
    input  logic                           last_of_fragment,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           channel,
    output logic [7:0]                     out_byte,
    output logic                           byte_valid,
    output logic                           end_of_fragment,
    output logic                           end_of_message,
    output logic [fbr_pkg::LEN_W-1:0]      message_length
);
    import fbr_pkg::*;

    logic              item_fire, res_fire;
    res_t              res;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;

    assign item_fire = in_valid && in_ready;

    fbr_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .item_fire         (item_fire),
        .operation         (operation),
        .rx_byte           (rx_byte),
        .first_of_fragment (first_of_fragment),
        .last_of_fragment  (last_of_fragment),
        .res_fire          (res_fire),
        .res               (res),
        .mem_we            (mem_we),
        .mem_waddr         (mem_waddr),
        .mem_wdata         (mem_wdata),
        .mem_re            (mem_re),
        .mem_raddr         (mem_raddr)
    );

    fbr_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fbr_outq u_outq (
        .clk             (clk),
        .rst_n           (rst_n),
        .res_fire        (res_fire),
        .res             (res),
        .mem_rdata       (mem_rdata),
        .can_take        (in_ready),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .channel         (channel),
        .out_byte        (out_byte),
        .byte_valid      (byte_valid),
        .end_of_fragment (end_of_fragment),
        .end_of_message  (end_of_message),
        .message_length  (message_length)
    );

endmodule

>>> hdl/fbr_ram.sv
module fbr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

>>> hdl/fbr_ctrl.sv
module fbr_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           item_fire,
    input  logic                           operation,
    input  logic [7:0]                     rx_byte,
    input  logic                           first_of_fragment,
    input  logic                           last_of_fragment,
    output logic                           res_fire,
    output fbr_pkg::res_t                  res,
    output logic                           mem_we,
    output logic [fbr_pkg::ADDR_W-1:0]     mem_waddr,
    output logic [7:0]                     mem_wdata,
    output logic                           mem_re,
    output logic [fbr_pkg::ADDR_W-1:0]     mem_raddr
);
    import fbr_pkg::*;

    logic              link_reg;
    logic [7:0]        msg_cmd_reg, ping_cmd_reg, cancel_cmd_reg, error_cmd_reg;

    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  exp_reg, exp_next;
    logic [7:0]        held_reg, held_next;
    logic [BIF_W-1:0]  bif_reg, bif_next;
    logic              init_reg, init_next;
    logic [7:0]        lhb_reg, lhb_next;
    mode_t             mode_reg, mode_next;
    logic [LEN_W-1:0]  rp_reg, rp_next;
    logic [FPOS_W-1:0] fp_reg, fp_next;
    logic [7:0]        seq_reg, seq_next;
    logic [7:0]        code_reg, code_next;
    logic              txi_reg, txi_next;

    logic [BIF_W-1:0]  pos;
    logic [FPOS_W-1:0] hdr, used, cap, chunk, flen;
    logic [LEN_W:0]    remain;
    logic              drop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg       <= 1'b0;
            msg_cmd_reg    <= 8'd131;
            ping_cmd_reg   <= 8'd129;
            cancel_cmd_reg <= 8'd190;
            error_cmd_reg  <= 8'd191;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LINK:   link_reg       <= cfg_data[0];
                CFG_MSG:    msg_cmd_reg    <= cfg_data;
                CFG_PING:   ping_cmd_reg   <= cfg_data;
                CFG_CANCEL: cancel_cmd_reg <= cfg_data;
                CFG_ERROR:  error_cmd_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            exp_reg  <= '0;
            held_reg <= '0;
            bif_reg  <= '0;
            init_reg <= 1'b0;
            lhb_reg  <= '0;
            mode_reg <= MODE_IDLE;
            rp_reg   <= '0;
            fp_reg   <= '0;
            seq_reg  <= '0;
            code_reg <= '0;
            txi_reg  <= 1'b1;
        end
        else
        begin
            fill_reg <= fill_next;
            exp_reg  <= exp_next;
            held_reg <= held_next;
            bif_reg  <= bif_next;
            init_reg <= init_next;
            lhb_reg  <= lhb_next;
            mode_reg <= mode_next;
            rp_reg   <= rp_next;
            fp_reg   <= fp_next;
            seq_reg  <= seq_next;
            code_reg <= code_next;
            txi_reg  <= txi_next;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        exp_next  = exp_reg;
        held_next = held_reg;
        bif_next  = bif_reg;
        init_next = init_reg;
        lhb_next  = lhb_reg;
        mode_next = mode_reg;
        rp_next   = rp_reg;
        fp_next   = fp_reg;
        seq_next  = seq_reg;
        code_next = code_reg;
        txi_next  = txi_reg;

        mem_we    = 1'b0;
        mem_waddr = fill_reg[ADDR_W-1:0];
        mem_wdata = rx_byte;
        mem_re    = 1'b0;
        mem_raddr = rp_reg[ADDR_W-1:0];
        res_fire  = 1'b0;
        res       = '0;
        res.len   = exp_reg;
        res.valid = 1'b1;
        res.chan  = 1'b1;
        drop      = 1'b0;

        pos    = '0;
        hdr    = txi_reg ? FPOS_W'(3) : FPOS_W'(1);
        used   = (fp_reg > hdr) ? fp_reg - hdr : '0;
        remain = ((exp_reg > rp_reg) ? {1'b0, exp_reg - rp_reg} : '0) + (LEN_W+1)'(used);
        cap    = txi_reg ? FPOS_W'(INIT_PAYLOAD) : FPOS_W'(CONT_PAYLOAD);
        chunk  = (remain < (LEN_W+1)'(cap)) ? remain[FPOS_W-1:0] : cap;
        flen   = hdr + chunk;

        if (item_fire && !operation && mode_reg == MODE_IDLE)
        begin
            if (first_of_fragment)
                pos = '0;
            else
                pos = (bif_reg < POS_MAX) ? bif_reg + 1'b1 : POS_MAX;
            if (first_of_fragment)
            begin
                if (rx_byte >= INIT_MARK)
                begin
                    init_next = 1'b1;
                    held_next = rx_byte;
                    exp_next  = '0;
                    lhb_next  = '0;
                    fill_next = '0;
                end
                else
                    init_next = 1'b0;
            end
            bif_next = pos;

            if (init_next && pos == BIF_W'(1))
            begin
                lhb_next = rx_byte;
                exp_next = clamp_len({rx_byte, 8'h00});
            end
            else if (init_next && pos == BIF_W'(2))
                exp_next = clamp_len({lhb_reg, rx_byte});
            else if (pos >= (init_next ? BIF_W'(3) : BIF_W'(1)) && fill_next < exp_next)
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_next[ADDR_W-1:0];
                fill_next = fill_next + 1'b1;
            end

            // message complete: pick the response from the held command
            if (last_of_fragment && fill_next >= exp_next)
            begin
                fill_next = '0;
                rp_next   = '0;
                fp_next   = '0;
                seq_next  = '0;
                txi_next  = 1'b1;
                if (held_next == msg_cmd_reg)
                    mode_next = MODE_REQ;
                else if (held_next == ping_cmd_reg)
                begin
                    if (exp_next == '0 || !link_reg)
                    begin
                        mode_next = MODE_IDLE;
                        exp_next  = '0;
                    end
                    else
                        mode_next = MODE_PING;
                end
                else
                begin
                    code_next = (held_next == cancel_cmd_reg) ? CODE_CANCEL : CODE_OTHER;
                    if (!link_reg)
                    begin
                        mode_next = MODE_IDLE;
                        exp_next  = '0;
                    end
                    else
                        mode_next = MODE_ERR;
                end
            end
        end
        else if (item_fire && operation && mode_reg != MODE_IDLE)
        begin
            unique case (mode_reg)
                MODE_REQ:
                begin
                    res.chan = 1'b0;
                    if (exp_reg == '0)
                    begin
                        res.valid = 1'b0;
                        res.eom   = 1'b1;
                    end
                    else
                    begin
                        res.use_mem = 1'b1;
                        mem_re      = 1'b1;
                        rp_next     = rp_reg + 1'b1;
                        res.eom     = (rp_next >= exp_reg);
                    end
                end
                MODE_ERR:
                begin
                    case (fp_reg)
                        FPOS_W'(0): res.data = error_cmd_reg;
                        FPOS_W'(1): res.data = 8'h00;
                        FPOS_W'(2): res.data = 8'h01;
                        default:    res.data = code_reg;
                    endcase
                    if (fp_reg >= FPOS_W'(3))
                    begin
                        res.eof = 1'b1;
                        res.eom = 1'b1;
                    end
                    else
                        fp_next = fp_reg + 1'b1;
                end
                MODE_PING:
                begin
                    if (txi_reg && fp_reg == FPOS_W'(0))
                        res.data = ping_cmd_reg;
                    else if (txi_reg && fp_reg == FPOS_W'(1))
                        res.data = 8'(exp_reg >> 8);
                    else if (txi_reg && fp_reg == FPOS_W'(2))
                        res.data = exp_reg[7:0];
                    else if (!txi_reg && fp_reg == FPOS_W'(0))
                        res.data = seq_reg;
                    else
                    begin
                        res.use_mem = 1'b1;
                        mem_re      = 1'b1;
                        rp_next     = rp_reg + 1'b1;
                    end
                    if ({1'b0, fp_reg} + 1'b1 >= {1'b0, flen})
                    begin
                        res.eof = 1'b1;
                        fp_next = '0;
                        if (txi_reg)
                            txi_next = 1'b0;
                        else
                            seq_next = seq_reg + 1'b1;
                        res.eom = (rp_next >= exp_reg);
                    end
                    else
                        fp_next = fp_reg + 1'b1;
                end
                default: ;
            endcase

            drop     = res.chan && !link_reg;
            res_fire = !drop;
            if (res.eom)
            begin
                mode_next = MODE_IDLE;
                exp_next  = '0;
                rp_next   = '0;
                fp_next   = '0;
                seq_next  = '0;
                txi_next  = 1'b1;
            end
        end
    end

endmodule

>>> hdl/fbr_outq.sv
module fbr_outq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       res_fire,
    input  fbr_pkg::res_t              res,
    input  logic [7:0]                 mem_rdata,
    output logic                       can_take,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       channel,
    output logic [7:0]                 out_byte,
    output logic                       byte_valid,
    output logic                       end_of_fragment,
    output logic                       end_of_message,
    output logic [fbr_pkg::LEN_W-1:0]  message_length
);
    import fbr_pkg::*;

    // first stage waits for the ram read, second is the output register
    logic p1_valid_reg, p2_valid_reg;
    res_t p1_reg, p2_reg;
    res_t p1_out;
    logic p1_move;

    assign p1_move  = p1_valid_reg && (!p2_valid_reg || out_ready);
    assign can_take = !p1_valid_reg || p1_move;

    always_comb
    begin
        p1_out      = p1_reg;
        p1_out.data = p1_reg.use_mem ? mem_rdata : p1_reg.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            if (can_take)
                p1_valid_reg <= res_fire;
            if (p1_move)
                p2_valid_reg <= 1'b1;
            else if (out_ready)
                p2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && res_fire)
            p1_reg <= res;
        if (p1_move)
            p2_reg <= p1_out;
    end

    assign out_valid       = p2_valid_reg;
    assign channel         = p2_reg.chan;
    assign out_byte        = p2_reg.data;
    assign byte_valid      = p2_reg.valid;
    assign end_of_fragment = p2_reg.eof;
    assign end_of_message  = p2_reg.eom;
    assign message_length  = p2_reg.len;

endmodule

>>> hdl/fbr_checker.sv
module fbr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           channel,
    input logic                           byte_valid,
    input logic                           end_of_fragment,
    input logic                           end_of_message,
    input logic [fbr_pkg::LEN_W-1:0]      message_length
);
    import fbr_pkg::*;

    // stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_req_no_eof: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !channel |-> !end_of_fragment)
        else $error("fragment end on request channel");

    // the empty-request marker is the whole request
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> end_of_message && !channel && message_length == '0)
        else $error("bad zero-length marker");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> message_length <= LEN_W'(STORE_DEPTH))
        else $error("message length beyond store");

endmodule

bind fido_ble_fragment_reassembler fbr_checker u_fbr_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import fbr_pkg::*;

    typedef struct {
        logic        chan;
        logic [7:0]  data;
        logic        valid;
        logic        eof;
        logic        eom;
        logic [10:0] len;
    } reply_t;

    class fbr_scoreboard;
        logic [7:0] store [STORE_DEPTH];
        int         fill;
        int         exp_len;
        logic [7:0] held_cmd;
        int         bif;
        bit         is_init;
        logic [7:0] len_hi;
        mode_t      mode;
        int         rd_ptr;
        int         fpos;
        logic [7:0] seq_num;
        logic [7:0] err_code;
        bit         tx_init;
        bit         link;
        logic [7:0] msg_cmd, ping_cmd, cancel_cmd, err_cmd;
        reply_t     replies [$];
        int         errors;

        function new();
            fill = 0; held_cmd = 0; bif = 0; is_init = 0; len_hi = 0; err_code = 0;
            errors = 0;
            link = 0; msg_cmd = 131; ping_cmd = 129; cancel_cmd = 190; err_cmd = 191;
            end_output();
        endfunction

        task report(input string what);
            errors++;
            $display("mismatch @%0t: %s", $time, what);
        endtask

        function void set_reg(input logic [2:0] idx, input logic [7:0] v);
            case (idx)
                CFG_LINK:   link = v[0];
                CFG_MSG:    msg_cmd = v;
                CFG_PING:   ping_cmd = v;
                CFG_CANCEL: cancel_cmd = v;
                CFG_ERROR:  err_cmd = v;
                default: ;
            endcase
        endfunction

        function int clamp(input int v);
            return v > STORE_DEPTH ? STORE_DEPTH : v;
        endfunction

        function void end_output();
            mode = MODE_IDLE; exp_len = 0; rd_ptr = 0; fpos = 0; seq_num = 0; tx_init = 1;
        endfunction

        function void complete();
            fill = 0; rd_ptr = 0; fpos = 0; seq_num = 0; tx_init = 1;
            if (held_cmd == msg_cmd)
                mode = MODE_REQ;
            else if (held_cmd == ping_cmd) begin
                if (exp_len == 0 || !link) end_output();
                else mode = MODE_PING;
            end else begin
                err_code = (held_cmd == cancel_cmd) ? CODE_CANCEL : CODE_OTHER;
                if (!link) end_output();
                else mode = MODE_ERR;
            end
        endfunction

        function void take_byte(input logic [7:0] b, input bit f, input bit l);
            int pos;
            int hdr;
            if (mode != MODE_IDLE)
                return;
            if (f) begin
                pos = 0;
                if (b >= INIT_MARK) begin
                    is_init = 1; held_cmd = b; exp_len = 0; len_hi = 0; fill = 0;
                end else
                    is_init = 0;
            end else
                pos = bif < 1023 ? bif + 1 : 1023;
            bif = pos;
            hdr = is_init ? 3 : 1;
            if (is_init && pos == 1) begin
                len_hi = b;
                exp_len = clamp(int'(b) << 8);
            end else if (is_init && pos == 2)
                exp_len = clamp(int'({len_hi, b}));
            else if (pos >= hdr && fill < exp_len && fill < STORE_DEPTH) begin
                store[fill] = b;
                fill++;
            end
            if (l && fill >= exp_len)
                complete();
        endfunction

        function void pull();
            reply_t r;
            int hdr, used, remain, cap, chunk, flen;
            if (mode == MODE_IDLE)
                return;
            r.chan = 1; r.data = 0; r.valid = 1; r.eof = 0; r.eom = 0; r.len = 11'(exp_len);
            if (mode == MODE_REQ) begin
                r.chan = 0;
                if (exp_len == 0) begin
                    r.valid = 0; r.eom = 1;
                end else begin
                    r.data = store[rd_ptr];
                    rd_ptr++;
                    r.eom = rd_ptr >= exp_len;
                end
            end else if (mode == MODE_ERR) begin
                case (fpos)
                    0: r.data = err_cmd;
                    1: r.data = 8'h00;
                    2: r.data = 8'h01;
                    default: r.data = err_code;
                endcase
                if (fpos >= 3) begin
                    r.eof = 1; r.eom = 1;
                end else
                    fpos++;
            end else begin
                hdr = tx_init ? 3 : 1;
                used = fpos > hdr ? fpos - hdr : 0;
                remain = (exp_len > rd_ptr ? exp_len - rd_ptr : 0) + used;
                cap = tx_init ? INIT_PAYLOAD : CONT_PAYLOAD;
                chunk = remain < cap ? remain : cap;
                flen = hdr + chunk;
                if (tx_init && fpos == 0) r.data = ping_cmd;
                else if (tx_init && fpos == 1) r.data = 8'(exp_len >> 8);
                else if (tx_init && fpos == 2) r.data = 8'(exp_len);
                else if (!tx_init && fpos == 0) r.data = seq_num;
                else begin
                    r.data = store[rd_ptr];
                    rd_ptr++;
                end
                if (fpos + 1 >= flen) begin
                    r.eof = 1;
                    fpos = 0;
                    if (tx_init) tx_init = 0;
                    else seq_num++;
                    r.eom = rd_ptr >= exp_len;
                end else
                    fpos++;
            end
            if (r.chan && !link) begin
                if (r.eom) end_output();
                return;
            end
            replies.push_back(r);
            if (r.eom) end_output();
        endfunction

        function void note_input(input bit op, input logic [7:0] b, input bit f, input bit l);
            if (op) pull();
            else take_byte(b, f, l);
        endfunction

        task check_result(input reply_t got);
            reply_t want;
            if (replies.size() == 0) begin
                report("output beat with nothing expected");
                return;
            end
            want = replies.pop_front();
            if (got.chan !== want.chan || got.data !== want.data || got.valid !== want.valid
                || got.eof !== want.eof || got.eom !== want.eom || got.len !== want.len)
                report($sformatf("got ch%0b %h v%0b eof%0b eom%0b len%0d, want ch%0b %h v%0b eof%0b eom%0b len%0d",
                    got.chan, got.data, got.valid, got.eof, got.eom, got.len,
                    want.chan, want.data, want.valid, want.eof, want.eom, want.len));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_write = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic operation = 0;
    logic [7:0] rx_byte = '0;
    logic first_of_fragment = 0;
    logic last_of_fragment = 0;
    logic out_valid;
    logic out_ready = 0;
    logic channel;
    logic [7:0] out_byte;
    logic byte_valid;
    logic end_of_fragment;
    logic end_of_message;
    logic [LEN_W-1:0] message_length;

    fbr_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;
    int items = 0;
    int cycles = 0;

    fido_ble_fragment_reassembler uut (.*);

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > 600000) begin
            $display("** fido_ble_fragment_reassembler: FAILED **");
            $finish;
        end
    end

    // receiver side: random stalls, plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_off > 0) begin
            hold_off--;
            out_ready = 0;
        end else
            out_ready = $urandom_range(99) >= stall_pct;
    end

    always @(posedge clk) begin
        reply_t r;
        if (out_valid && out_ready) begin
            r.chan = channel; r.data = out_byte; r.valid = byte_valid;
            r.eof = end_of_fragment; r.eom = end_of_message; r.len = message_length;
            sb.check_result(r);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send(input bit op, input logic [7:0] b, input bit f, input bit l);
        while ($urandom_range(99) < idle_pct) begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1; operation = op; rx_byte = b;
        first_of_fragment = f; last_of_fragment = l;
        do @(posedge clk); while (!in_ready);
        sb.note_input(op, b, f, l);
        items++;
        @(negedge clk);
    endtask

    task automatic drain_pulls();
        while (sb.mode != MODE_IDLE) begin
            // a byte arriving while output is pending is ignored
            if ($urandom_range(19) == 0)
                send(0, 8'($urandom), 1'($urandom), 1'($urandom));
            send(1, 8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic send_message(input logic [7:0] cmd, input int len, input bit broken);
        int left, n, k, seq;
        left = len;
        n = left < INIT_PAYLOAD ? left : INIT_PAYLOAD;
        send(0, cmd, 1, 0);
        send(0, 8'(len >> 8), 0, 0);
        send(0, 8'(len), 0, n == 0);
        for (k = 0; k < n; k++)
            send(0, 8'($urandom), 0, k == n - 1 || (broken && $urandom_range(15) == 0));
        left -= n;
        seq = 0;
        while (left > 0) begin
            n = left < CONT_PAYLOAD ? left : CONT_PAYLOAD;
            send(0, 8'(seq) & 8'h7F, 1, 0);
            for (k = 0; k < n; k++)
                send(0, 8'($urandom), 0, k == n - 1);
            left -= n;
            seq++;
        end
        drain_pulls();
    endtask

    task automatic wait_idle();
        in_valid = 0;
        while (sb.replies.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
        cfg_write = 1; cfg_index = idx; cfg_data = v;
        @(negedge clk);
        cfg_write = 0;
        sb.set_reg(idx, v);
    endtask

    task automatic set_all(input bit lk, input logic [7:0] m, input logic [7:0] p,
                           input logic [7:0] c, input logic [7:0] e);
        write_reg(CFG_LINK, {7'b0, lk});
        write_reg(CFG_MSG, m);
        write_reg(CFG_PING, p);
        write_reg(CFG_CANCEL, c);
        write_reg(CFG_ERROR, e);
    endtask

    task automatic random_round();
        int r, len, k;
        logic [7:0] cmd;
        r = $urandom_range(99);
        len = ($urandom_range(99) < 3) ? $urandom_range(200, 400) : $urandom_range(0, 130);
        if (r < 30) cmd = sb.msg_cmd;
        else if (r < 50) cmd = sb.ping_cmd;
        else if (r < 62) cmd = sb.cancel_cmd;
        else cmd = 8'($urandom_range(128, 255));
        if (cmd < INIT_MARK) cmd = 8'($urandom_range(128, 255));
        if (r < 85)
            send_message(cmd, len, r >= 75);
        else begin
            for (k = $urandom_range(1, 6); k > 0; k--)
                send($urandom_range(3) == 0, 8'($urandom), 1'($urandom), 1'($urandom));
            drain_pulls();
        end
    endtask

    initial begin
        int p;
        int lk [6] = '{1, 1, 0, 1, 1, 1};
        int mc [6] = '{131, 8'h80, 8'hA5, 8'h90, 8'h83, 8'hFF};
        int pc [6] = '{129, 8'hFF, 8'h81, 8'h90, 8'h85, 8'hFE};
        int cc [6] = '{190, 8'hC0, 8'hBE, 8'h90, 8'h85, 8'h00};
        int ec [6] = '{191, 8'h00, 8'hFF, 8'hFF, 8'h5A, 8'hBF};
        int ip [6] = '{0, 87, 0, 18, 0, 87};
        int sp [6] = '{0, 0, 87, 18, 0, 87};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        write_reg(CFG_LINK, 1);

        send(1, 8'h00, 0, 0);                  // pull while idle
        send_message(131, 0, 0);               // zero-length request marker
        send_message(131, 3, 0);
        send_message(129, 0, 0);               // zero-length ping: silent
        send_message(129, 70, 0);              // ping echo over two fragments
        send_message(190, 0, 0);               // cancel
        send_message(8'hFF, 1, 0);             // unknown command
        send(0, 131, 1, 1);                    // header cut short
        drain_pulls();
        send(0, 8'h7F, 1, 1);                  // stray cont
        drain_pulls();
        send(0, 8'hFF, 1, 0);                  // clamped length, never finished
        send(0, 8'hFF, 0, 0);
        send(0, 8'hFF, 0, 1);
        send(0, 8'h00, 0, 1);                  // continues without first mark
        wait_idle();

        for (p = 0; p < 6; p++) begin
            set_all(1'(lk[p]), 8'(mc[p]), 8'(pc[p]), 8'(cc[p]), 8'(ec[p]));
            idle_pct = ip[p];
            stall_pct = sp[p];
            if (p == 4) hold_off = 400;
            while (items < 200 + (p + 1) * 240)
                random_round();
            wait_idle();
        end

        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.replies.size() == 0)
            $display("** fido_ble_fragment_reassembler: PASSED **");
        else
            $display("** fido_ble_fragment_reassembler: FAILED **");
        $finish;
    end
endmodule
